FILE: rtl/core/adsr_pkg.sv
package adsr_pkg;

    // configuration register width and index codes
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd3;

    localparam logic [CFG_W-1:0] LEN_RESET = 16'd441;

    // ratio is Q16 with values up to 1.0, so 17 quotient bits
    localparam int FRAC_W = 16;
    localparam int QUO_W  = FRAC_W + 1;

    typedef struct packed {
        logic        [CFG_W-1:0] attack_len;
        logic        [CFG_W-1:0] decay_len;
        logic signed [CFG_W-1:0] sustain;
        logic        [CFG_W-1:0] release_len;
    } adsr_cfg_t;

endpackage

FILE: rtl/core/adsr_cfg.sv
module adsr_cfg
    import adsr_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output adsr_cfg_t            cfg
);

    localparam int MW = (TIME_BITS < CFG_W) ? TIME_BITS : CFG_W;
    localparam logic [CFG_W-1:0] TIME_MASK = CFG_W'((17'd1 << MW) - 17'd1);

    adsr_cfg_t cfg_reg;
    adsr_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ATTACK:  cfg_next.attack_len  = cfg_data & TIME_MASK;
                REG_DECAY:   cfg_next.decay_len   = cfg_data & TIME_MASK;
                REG_SUSTAIN: cfg_next.sustain     = cfg_data;
                REG_RELEASE: cfg_next.release_len = cfg_data & TIME_MASK;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attack_len  <= LEN_RESET;
            cfg_reg.decay_len   <= LEN_RESET;
            cfg_reg.sustain     <= '0;
            cfg_reg.release_len <= LEN_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/adsr_div.sv
module adsr_div
    import adsr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [CFG_W-1:0] num,
    input  logic [CFG_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quot
);

    // round(num * 2^16 / den) for num <= den, one quotient bit per cycle
    localparam int DW  = CFG_W + QUO_W;
    localparam int CNW = $clog2(QUO_W);

    logic [CFG_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CFG_W-1:0] den_reg, den_next;
    logic [CNW-1:0]   cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DW-1:0]    dividend;
    logic [CFG_W:0]   trial;
    logic             fits;

    assign dividend = {1'b0, num, {FRAC_W{1'b0}}} + DW'(den[CFG_W-1:1]);
    assign trial    = {rem_reg, quo_reg[QUO_W-1]};
    assign fits     = (trial >= {1'b0, den_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // dividend < den * 2^17, so the high part is already below den
            rem_next  = dividend[DW-1:QUO_W];
            quo_next  = dividend[QUO_W-1:0];
            den_next  = den;
            cnt_next  = CNW'(QUO_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? CFG_W'(trial - {1'b0, den_reg}) : trial[CFG_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

FILE: rtl/core/adsr_envelope_generator_unit.sv
// a held level (zero attack, sustain, finished or zero release) goes from accept straight to
// the output step; a curve passes load, the 17-step divider, done, square, scale and output
// a word is taken only in the idle state, so the 17-step ratio divider holds off the next
// word on a curve; the next word is taken as soon as the result sits in the output register,
// and a full output register without m_ready stalls the result in the output step
// reset: lengths 441, sustain 0, elapsed counter 0, gate released, channels empty
module adsr_envelope_generator_unit
    import adsr_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_gate_on,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [15:0]   m_gain_level
);

    localparam int CW  = TIME_BITS + 2;
    localparam int SW  = (CW > CFG_W + 1) ? CW : CFG_W + 1;
    localparam int PW  = 2 * QUO_W;
    localparam int GW  = QUO_W + 2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_SQR   = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [1:0] SEG_ATTACK  = 2'd0;
    localparam logic [1:0] SEG_DECAY   = 2'd1;
    localparam logic [1:0] SEG_RELEASE = 2'd2;

    localparam logic signed [15:0] GAIN_MAX = 16'sh7FFF;
    localparam logic signed [15:0] GAIN_MIN = 16'sh8000;
    localparam logic [QUO_W-1:0]   UNITY    = QUO_W'(1) << FRAC_W;
    localparam logic [PW-1:0]      HALF     = PW'(1) << (FRAC_W - 1);

    adsr_cfg_t cfg;

    logic [2:0]          state_reg, state_next;
    logic [1:0]          seg_reg, seg_next;
    logic [CFG_W-1:0]    num_reg, num_next;
    logic [CFG_W-1:0]    den_reg, den_next;
    logic [QUO_W-1:0]    sq_reg, sq_next;
    logic signed [15:0]  result_reg, result_next;
    logic [CW-1:0]       elapsed_reg, elapsed_next;
    logic                gate_reg, gate_next;
    logic                m_valid_reg, m_valid_next;
    logic signed [15:0]  m_gain_reg, m_gain_next;

    logic                accept;
    logic                div_start;
    logic                div_done;
    logic [QUO_W-1:0]    div_quot;

    logic [SW-1:0]       t_sw, a_sw, ad_sw, r_sw;
    logic [SW-1:0]       dec_num, rel_num;
    logic                in_attack, in_decay, in_release, advance;

    logic [QUO_W-1:0]    mul_a, mul_b, scale_k;
    logic [PW-1:0]       product, rounded;
    logic signed [GW-1:0] offset, gain_wide;

    adsr_cfg #(
        .TIME_BITS (TIME_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    adsr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg),
        .den     (den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // any gate edge restarts the elapsed count
    assign t_sw       = (s_gate_on != gate_reg) ? '0 : SW'(elapsed_reg);
    assign a_sw       = SW'(cfg.attack_len);
    assign ad_sw      = a_sw + SW'(cfg.decay_len);
    assign r_sw       = SW'(cfg.release_len);
    assign dec_num    = ad_sw - t_sw;
    assign rel_num    = r_sw - t_sw;
    assign in_attack  = (t_sw <= a_sw);
    assign in_decay   = (t_sw <= ad_sw);
    assign in_release = (t_sw <= r_sw);
    assign advance    = s_gate_on ? in_decay : in_release;

    // shared multiplier: ratio squared, then the squared ratio scaled to the segment span
    always_comb begin
        case (seg_reg)
            SEG_DECAY:   scale_k = QUO_W'(16'h8000) - {cfg.sustain[15], cfg.sustain};
            SEG_RELEASE: scale_k = QUO_W'(16'h8000) + {cfg.sustain[15], cfg.sustain};
            default:     scale_k = UNITY;
        endcase
        if (seg_reg == SEG_DECAY) begin
            offset = GW'(cfg.sustain);
        end else begin
            offset = GW'(GAIN_MIN);
        end
    end

    assign mul_a     = (state_reg == ST_SCALE) ? sq_reg : div_quot;
    assign mul_b     = (state_reg == ST_SCALE) ? scale_k : div_quot;
    assign product   = PW'(mul_a) * PW'(mul_b);
    assign rounded   = (product + HALF) >> FRAC_W;
    assign gain_wide = $signed({2'b00, rounded[QUO_W-1:0]}) + offset;

    always_comb begin
        state_next   = state_reg;
        seg_next     = seg_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        sq_next      = sq_reg;
        result_next  = result_reg;
        elapsed_next = elapsed_reg;
        gate_next    = gate_reg;
        div_start    = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        m_gain_next  = m_gain_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    gate_next    = s_gate_on;
                    elapsed_next = advance ? CW'(t_sw + 1'b1) : CW'(t_sw);
                    state_next   = ST_LOAD;
                    if (s_gate_on) begin
                        if (in_attack) begin
                            seg_next = SEG_ATTACK;
                            num_next = t_sw[CFG_W-1:0];
                            den_next = cfg.attack_len;
                            if (cfg.attack_len == '0) begin
                                result_next = GAIN_MAX;
                                state_next  = ST_OUT;
                            end
                        end else if (in_decay) begin
                            seg_next = SEG_DECAY;
                            num_next = dec_num[CFG_W-1:0];
                            den_next = cfg.decay_len;
                        end else begin
                            result_next = cfg.sustain;
                            state_next  = ST_OUT;
                        end
                    end else begin
                        seg_next = SEG_RELEASE;
                        num_next = rel_num[CFG_W-1:0];
                        den_next = cfg.release_len;
                        if (!in_release || (cfg.release_len == '0)) begin
                            result_next = GAIN_MIN;
                            state_next  = ST_OUT;
                        end
                    end
                end
            end
            ST_LOAD: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_SQR;
                end
            end
            ST_SQR: begin
                sq_next    = rounded[QUO_W-1:0];
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                if (gain_wide > GW'(GAIN_MAX)) begin
                    result_next = GAIN_MAX;
                end else if (gain_wide < GW'(GAIN_MIN)) begin
                    result_next = GAIN_MIN;
                end else begin
                    result_next = gain_wide[15:0];
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_gain_next  = result_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            elapsed_reg <= '0;
            gate_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            gate_reg    <= gate_next;
            m_valid_reg <= m_valid_next;
        end
        seg_reg    <= seg_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        sq_reg     <= sq_next;
        result_reg <= result_next;
        m_gain_reg <= m_gain_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_gain_level = m_gain_reg;

    // one word in flight: no second accept until the result is handed off
    ap_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("word accepted while busy");

    ap_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide step");

    ap_edge_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_gate_on != gate_reg)) |=> (elapsed_reg <= CW'(1)))
        else $error("gate edge did not restart the elapsed count");

    ap_out_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_OUT) && m_valid_reg && !m_ready) |=> (state_reg == ST_OUT))
        else $error("result dropped while output register full");

endmodule

FILE: tb/tb_adsr_envelope_generator_unit.sv
`timescale 1ns / 100ps

module tb_adsr_envelope_generator_unit;
    import adsr_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_TICKS = 40;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_ATTACK;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic                 s_gate_on = 1'b0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic signed [15:0]   m_gain_level;

    // predicted envelope state
    adsr_cfg_t          envelope_cfg;
    logic [17:0]        elapsed_count;
    bit                 gate_prev;
    logic signed [15:0] expected_gains[$];

    int mismatches = 0;
    int cycles     = 0;
    int words_sent = 0;
    int stall_left = 0;
    bit idling_on  = 1'b1;

    always #2 aclk = ~aclk;

    adsr_envelope_generator_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_gate_on    (s_gate_on),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_gain_level (m_gain_level)
    );

    // Q16 square of num/den, ratio rounded half up
    function automatic longint square_ratio(input longint num, input longint den);
        longint q;
        q = (num * 65536 + den / 2) / den;
        return (q * q + 32768) >> 16;
    endfunction

    function automatic logic signed [15:0] predict_gain(input bit gate);
        longint a, d, r, s, t, g;
        bit     advance;
        a = envelope_cfg.attack_len;
        d = envelope_cfg.decay_len;
        r = envelope_cfg.release_len;
        s = longint'($signed(envelope_cfg.sustain));
        advance = 1'b1;
        if (gate != gate_prev)
            elapsed_count = '0;
        t = elapsed_count;
        if (gate) begin
            if (t <= a) begin
                g = (a == 0) ? 32768 : square_ratio(t, a) - 32768;
            end else if (t <= a + d) begin
                g = ((square_ratio(a + d - t, d) * (32768 - s) + 32768) >> 16) + s;
            end else begin
                g = s;
                advance = 1'b0;
            end
        end else begin
            if (t > r) begin
                g = -32768;
                advance = 1'b0;
            end else if (r == 0) begin
                g = -32768;
            end else begin
                g = ((square_ratio(r - t, r) * (32768 + s) + 32768) >> 16) - 32768;
            end
        end
        if (advance)
            elapsed_count = elapsed_count + 1'b1;
        gate_prev = gate;
        if (g > 32767)
            g = 32767;
        else if (g < -32768)
            g = -32768;
        return g[15:0];
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_ATTACK:  envelope_cfg.attack_len  = value;
            REG_DECAY:   envelope_cfg.decay_len   = value;
            REG_SUSTAIN: envelope_cfg.sustain     = value;
            REG_RELEASE: envelope_cfg.release_len = value;
            default: ;
        endcase
    endtask

    // hold off the sender until every predicted gain has come back
    task automatic wait_idle;
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_gains.size() != 0);
    endtask

    task automatic set_envelope(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] d,
                                input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] r);
        wait_idle();
        write_reg(REG_ATTACK, a);
        write_reg(REG_DECAY, d);
        write_reg(REG_SUSTAIN, s);
        write_reg(REG_RELEASE, r);
    endtask

    task automatic send_gate(input bit gate);
        int gap;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_gate_on <= gate;
        do @(posedge aclk); while (!s_ready);
        expected_gains.push_back(predict_gain(gate));
        words_sent++;
    endtask

    function automatic logic [CFG_W-1:0] pick_len();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 16'hffff;
        if (pick == 1)
            return 16'h0000;
        if (pick < 4)
            return CFG_W'($urandom_range(0, 65535));
        return CFG_W'($urandom_range(1, 20));
    endfunction

    function automatic logic [CFG_W-1:0] pick_level();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 16'h7fff;
        if (pick == 1)
            return 16'h8000;
        return CFG_W'($urandom_range(0, 65535));
    endfunction

    // segment run length, often long enough to reach the end of the segment
    function automatic int run_len(input longint full);
        int cap;
        cap = (full > 64) ? 64 : int'(full);
        return $urandom_range(0, 1) ? cap : $urandom_range(1, cap);
    endfunction

    task automatic test_reset_state;
        // released gate after reset starts the release curve from the sustain level
        repeat (3) send_gate(1'b0);
        repeat (2) send_gate(1'b1);
    endtask

    task automatic test_zero_lengths;
        set_envelope(16'd0, 16'd0, 16'h8000, 16'd0);
        send_gate(1'b1);
        send_gate(1'b1);
        send_gate(1'b0);
        send_gate(1'b0);
    endtask

    task automatic test_full_scale;
        set_envelope(16'd1, 16'd1, 16'h7fff, 16'hffff);
        repeat (4) send_gate(1'b1);
        repeat (2) send_gate(1'b0);
        // lowest sustain: widest decay swing, release collapses to -32768
        set_envelope(16'd1, 16'hffff, 16'h8000, 16'd3);
        repeat (3) send_gate(1'b1);
        send_gate(1'b0);
    endtask

    task automatic test_retime_mid_segment;
        set_envelope(16'd4, 16'd4, 16'h4000, 16'd6);
        repeat (2) send_gate(1'b1);
        // gate unchanged, so the count carries on under new lengths
        set_envelope(16'd8, 16'd2, 16'hc000, 16'd6);
        repeat (3) send_gate(1'b1);
    endtask

    task automatic test_random_envelopes(input int count);
        int target;
        int phase_end;
        int held;
        int rel;
        target = words_sent + count;
        while (words_sent < target) begin
            set_envelope(pick_len(), pick_len(), pick_level(), pick_len());
            phase_end = words_sent + $urandom_range(30, 80);
            while (words_sent < phase_end) begin
                if ($urandom_range(0, 9) < 7) begin
                    held = run_len(longint'(envelope_cfg.attack_len)
                                   + longint'(envelope_cfg.decay_len) + 3);
                    rel  = run_len(longint'(envelope_cfg.release_len) + 3);
                    repeat (held) send_gate(1'b1);
                    repeat (rel) send_gate(1'b0);
                end else begin
                    repeat ($urandom_range(1, 8)) send_gate(1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    task automatic test_back_to_back;
        idling_on = 1'b0;
        test_random_envelopes(150);
    endtask

    // result side: random stall bursts and in-order check
    always @(posedge aclk) begin
        logic signed [15:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_gains.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected gain word: got %0d", m_gain_level);
            end else begin
                want = expected_gains.pop_front();
                if (m_gain_level !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("gain mismatch: expected %0d, got %0d", want, m_gain_level);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("adsr_envelope_generator_unit regression: fail");
            $finish;
        end
    end

    initial begin
        envelope_cfg.attack_len  = LEN_RESET;
        envelope_cfg.decay_len   = LEN_RESET;
        envelope_cfg.sustain     = '0;
        envelope_cfg.release_len = LEN_RESET;
        elapsed_count = '0;
        gate_prev     = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_zero_lengths();
        test_full_scale();
        test_retime_mid_segment();
        test_random_envelopes(630);
        test_back_to_back();

        wait_idle();
        repeat (SETTLE_TICKS) @(posedge aclk);
        if (mismatches == 0)
            $display("adsr_envelope_generator_unit regression: pass");
        else
            $display("adsr_envelope_generator_unit regression: fail");
        $finish;
    end

endmodule
